[hdl/kmes_pkg.sv]
package kmes_pkg;

    localparam int ROWS     = 8;
    localparam int COLS     = 5;
    localparam int NKEYS    = ROWS * COLS;
    localparam int IN_BITS  = 40;
    localparam int ROM_ROWS = 8;
    localparam int ROM_COLS = 5;
    localparam int CODE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

    localparam logic [CODE_W-1:0] SHIFT_RESET  = 8'd18;
    localparam logic [CODE_W-1:0] ENTER_RESET  = 8'd13;
    localparam logic [CODE_W-1:0] ESCAPE_RESET = 8'd27;

    localparam logic [CODE_W-1:0] CODE_ONE   = 8'h31;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;

    // slot entries resolve to the programmable enter and shift codes
    localparam logic [8:0] SLOT_ENTER = 9'h100;
    localparam logic [8:0] SLOT_SHIFT = 9'h101;

    localparam logic [8:0] KEYMAP [ROM_ROWS][ROM_COLS] = '{
        '{9'h042, 9'h04E, 9'h04D, 9'h02E, 9'h020},
        '{9'h048, 9'h04A, 9'h04B, 9'h04C, SLOT_ENTER},
        '{9'h056, 9'h043, 9'h058, 9'h05A, SLOT_SHIFT},
        '{9'h059, 9'h055, 9'h049, 9'h04F, 9'h050},
        '{9'h047, 9'h046, 9'h044, 9'h053, 9'h041},
        '{9'h036, 9'h037, 9'h038, 9'h039, 9'h030},
        '{9'h054, 9'h052, 9'h045, 9'h057, 9'h051},
        '{9'h035, 9'h034, 9'h033, 9'h032, 9'h031}
    };

    typedef struct packed {
        logic              hit;
        logic              press;
        logic [CODE_W-1:0] code;
        logic              chord_any;
        logic              chord_multi;
    } lane_res_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [CODE_W-1:0] key_code;
    } merge_out_t;

    function automatic logic [CODE_W-1:0] rom_code(
        input int                r,
        input int                c,
        input logic [CODE_W-1:0] shift_code,
        input logic [CODE_W-1:0] enter_code
    );
        logic [8:0]        v;
        logic [CODE_W-1:0] res;
        res = '0;
        if (r < ROM_ROWS && c < ROM_COLS) begin
            v = KEYMAP[r][c];
            if (v == SLOT_ENTER) begin
                res = enter_code;
            end else if (v == SLOT_SHIFT) begin
                res = shift_code;
            end else begin
                res = v[CODE_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

[hdl/key_matrix_edge_scanner.sv]
// Key matrix edge scanner, 8 rows by 5 columns.
// Input channel (s_valid/s_ready/s_key_down): one transfer is one full
// scan of the matrix, bit row*5+col set for a key that is down.
// Result channel (m_valid/m_ready/m_event_kind/m_key_code): one transfer
// per scan with the kind of edge (none, press, release) of the
// highest-indexed changed key and its code, the escape code when two or
// more of shift, '1' and space are down, or the previous code when no key changed.
// Result valid is registered and rises in the cycle after the input transfer.
// One scan is taken every cycle while s_ready is high: all rows are compared
// against the held bits in parallel and merged in the same cycle into the output register.
// A stalled receiver holds the result register; a new scan is still taken
// in the cycle the pending result transfers. s_ready drops only while a
// result waits and m_ready is low.
// Reset (aresetn low, synchronous) clears the held bits and the repeated
// code and restores shift 18, enter 13, escape 27. The cfg port writes a
// code register; write it only while the block is idle.
module key_matrix_edge_scanner
    import kmes_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_BITS-1:0]   s_key_down,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_event_kind,
    output logic [CODE_W-1:0]    m_key_code
);

    logic [CODE_W-1:0] shift_code_reg;
    logic [CODE_W-1:0] enter_code_reg;
    logic [CODE_W-1:0] escape_code_reg;
    logic [NKEYS-1:0]  held_reg;
    logic [CODE_W-1:0] last_code_reg;
    logic              m_valid_reg;
    logic [KIND_W-1:0] m_kind_reg;
    logic [CODE_W-1:0] m_code_reg;

    logic [NKEYS-1:0]                          down_vec;
    logic [ROWS-1:0][COLS-1:0][CODE_W-1:0]     codes;
    lane_res_t [ROWS-1:0]                      lane_res;
    merge_out_t                                merged;
    logic                                      s_fire;

    for (genvar k = 0; k < NKEYS; k++) begin : g_down
        if (k < IN_BITS) begin : g_sensed
            assign down_vec[k] = s_key_down[k];
        end else begin : g_unsensed
            assign down_vec[k] = 1'b0;
        end
    end

    for (genvar r = 0; r < ROWS; r++) begin : g_row
        for (genvar c = 0; c < COLS; c++) begin : g_col
            assign codes[r][c] = rom_code(r, c, shift_code_reg, enter_code_reg);
        end

        kmes_lane u_lane (
            .row_down   (down_vec[r*COLS +: COLS]),
            .row_held   (held_reg[r*COLS +: COLS]),
            .row_codes  (codes[r]),
            .shift_code (shift_code_reg),
            .res        (lane_res[r])
        );
    end

    kmes_merge u_merge (
        .lanes       (lane_res),
        .last_code   (last_code_reg),
        .escape_code (escape_code_reg),
        .res         (merged)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_code_reg  <= SHIFT_RESET;
            enter_code_reg  <= ENTER_RESET;
            escape_code_reg <= ESCAPE_RESET;
            held_reg        <= '0;
            last_code_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SHIFT:  shift_code_reg  <= cfg_wdata;
                    CFG_ENTER:  enter_code_reg  <= cfg_wdata;
                    CFG_ESCAPE: escape_code_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_fire) begin
                held_reg      <= down_vec;
                last_code_reg <= merged.key_code;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_kind_reg <= merged.event_kind;
            m_code_reg <= merged.key_code;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_key_code   = m_code_reg;

endmodule

[hdl/kmes_lane.sv]
module kmes_lane
    import kmes_pkg::*;
(
    input  logic [COLS-1:0]             row_down,
    input  logic [COLS-1:0]             row_held,
    input  logic [COLS-1:0][CODE_W-1:0] row_codes,
    input  logic [CODE_W-1:0]           shift_code,
    output lane_res_t                   res
);

    logic [COLS-1:0] changed;
    logic [COLS-1:0] chord_bits;

    always_comb begin
        changed = row_down ^ row_held;
        for (int c = 0; c < COLS; c++) begin
            chord_bits[c] = row_down[c] &&
                            (row_codes[c] == shift_code ||
                             row_codes[c] == CODE_ONE ||
                             row_codes[c] == CODE_SPACE);
        end
    end

    always_comb begin
        res.hit   = 1'b0;
        res.press = 1'b0;
        res.code  = '0;
        // highest changed column wins
        for (int c = 0; c < COLS; c++) begin
            if (changed[c]) begin
                res.hit   = 1'b1;
                res.press = row_down[c];
                res.code  = row_codes[c];
            end
        end
        res.chord_any   = |chord_bits;
        res.chord_multi = (chord_bits & (chord_bits - 1'b1)) != '0;
    end

endmodule

[hdl/kmes_merge.sv]
module kmes_merge
    import kmes_pkg::*;
(
    input  lane_res_t [ROWS-1:0] lanes,
    input  logic [CODE_W-1:0]    last_code,
    input  logic [CODE_W-1:0]    escape_code,
    output merge_out_t           res
);

    logic [ROWS-1:0] row_any;
    logic            row_multi;
    logic            chord;
    logic            hit;
    logic            press;
    logic [CODE_W-1:0] hit_code;

    always_comb begin
        row_multi = 1'b0;
        hit       = 1'b0;
        press     = 1'b0;
        hit_code  = '0;
        for (int r = 0; r < ROWS; r++) begin
            row_any[r] = lanes[r].chord_any;
            row_multi  = row_multi | lanes[r].chord_multi;
            if (lanes[r].hit) begin
                hit      = 1'b1;
                press    = lanes[r].press;
                hit_code = lanes[r].code;
            end
        end
        chord = row_multi || ((row_any & (row_any - 1'b1)) != '0);

        if (!hit) begin
            res.event_kind = KIND_NONE;
        end else if (press) begin
            res.event_kind = KIND_PRESS;
        end else begin
            res.event_kind = KIND_RELEASE;
        end

        if (chord) begin
            res.key_code = escape_code;
        end else if (hit) begin
            res.key_code = hit_code;
        end else begin
            res.key_code = last_code;
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import kmes_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [CODE_W-1:0] key_code;
    } key_event_t;

    class KeyEventScoreboard;
        logic [NKEYS-1:0]  held;
        logic [CODE_W-1:0] last_code;
        logic [CODE_W-1:0] shift_code;
        logic [CODE_W-1:0] enter_code;
        logic [CODE_W-1:0] escape_code;
        key_event_t        pending_events[$];
        int                errors;
        int                checked;
        int                presses;
        int                releases;
        int                escapes;

        function new();
            held        = '0;
            last_code   = '0;
            shift_code  = SHIFT_RESET;
            enter_code  = ENTER_RESET;
            escape_code = ESCAPE_RESET;
            errors      = 0;
            checked     = 0;
            presses     = 0;
            releases    = 0;
            escapes     = 0;
        endfunction

        function void set_codes(logic [CODE_W-1:0] s, logic [CODE_W-1:0] e,
                                logic [CODE_W-1:0] x);
            shift_code  = s;
            enter_code  = e;
            escape_code = x;
        endfunction

        function logic [CODE_W-1:0] code_at(int idx);
            logic [8:0] entry;
            if (idx / ROM_COLS >= ROM_ROWS) begin
                return '0;
            end
            entry = KEYMAP[idx / ROM_COLS][idx % ROM_COLS];
            if (entry == SLOT_ENTER) begin
                return enter_code;
            end else if (entry == SLOT_SHIFT) begin
                return shift_code;
            end
            return entry[CODE_W-1:0];
        endfunction

        function void note_scan(logic [IN_BITS-1:0] scan);
            int                chord_keys;
            logic [CODE_W-1:0] kc;
            key_event_t        ev;
            chord_keys    = 0;
            ev.event_kind = KIND_NONE;
            ev.key_code   = last_code;
            for (int i = 0; i < NKEYS; i++) begin
                kc = code_at(i);
                if (scan[i] && (kc == shift_code || kc == CODE_ONE || kc == CODE_SPACE)) begin
                    chord_keys++;
                end
                if (scan[i] != held[i]) begin
                    ev.event_kind = scan[i] ? KIND_PRESS : KIND_RELEASE;
                    ev.key_code   = kc;
                    held[i]       = scan[i];
                end
            end
            if (chord_keys >= 2) begin
                ev.key_code = escape_code;
                escapes++;
            end
            if (ev.event_kind == KIND_PRESS) begin
                presses++;
            end else if (ev.event_kind == KIND_RELEASE) begin
                releases++;
            end
            last_code = ev.key_code;
            pending_events.push_back(ev);
        endfunction

        function void check_event(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code);
            key_event_t ev;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result kind %0d code %02h", $time, kind, code);
                errors++;
                return;
            end
            ev = pending_events.pop_front();
            checked++;
            if (kind !== ev.event_kind) begin
                $display("%0t: event_kind expected %0d actual %0d",
                         $time, ev.event_kind, kind);
                errors++;
            end
            if (code !== ev.key_code) begin
                $display("%0t: key_code expected %02h actual %02h",
                         $time, ev.key_code, code);
                errors++;
            end
        endfunction
    endclass

    localparam logic [IN_BITS-1:0] ALL_KEYS = {IN_BITS{1'b1}};
    localparam int SPACE_IDX = 4;
    localparam int ENTER_IDX = 9;
    localparam int SHIFT_IDX = 14;
    localparam int ONE_IDX   = 39;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CODE_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [IN_BITS-1:0]   s_key_down;
    logic                 m_valid;
    logic                 m_ready;
    logic [KIND_W-1:0]    m_event_kind;
    logic [CODE_W-1:0]    m_key_code;

    KeyEventScoreboard  sb;
    logic [IN_BITS-1:0] cur_scan;
    logic               send_burst;
    int                 scans_sent;
    int                 settings_used;

    key_matrix_edge_scanner DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_down  (s_key_down),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_kind(m_event_kind),
        .m_key_code  (m_key_code)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic send_scan(logic [IN_BITS-1:0] scan);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            send_burst = ~send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_down <= scan;
        do @(posedge aclk); while (!s_ready);
        sb.note_scan(scan);
        cur_scan = scan;
        scans_sent++;
    endtask

    // hold off input until every pending event has transferred
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (sb.pending_events.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic program_codes(logic [CODE_W-1:0] s, logic [CODE_W-1:0] e,
                                 logic [CODE_W-1:0] x);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SHIFT;
        cfg_wdata <= s;
        @(posedge aclk);
        cfg_index <= CFG_ENTER;
        cfg_wdata <= e;
        @(posedge aclk);
        cfg_index <= CFG_ESCAPE;
        cfg_wdata <= x;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_codes(s, e, x);
        settings_used++;
    endtask

    function automatic logic [IN_BITS-1:0] next_scan(logic [IN_BITS-1:0] prev);
        int                 pick;
        int                 chord_pos[3];
        logic [IN_BITS-1:0] scan;
        chord_pos = '{SPACE_IDX, SHIFT_IDX, ONE_IDX};
        scan      = prev;
        pick      = $urandom_range(0, 99);
        if (pick < 58) begin
            repeat ($urandom_range(1, 3)) scan[$urandom_range(0, IN_BITS - 1)] ^= 1'b1;
        end else if (pick < 72) begin
            scan = prev;
        end else if (pick < 84) begin
            scan[chord_pos[$urandom_range(0, 2)]] = 1'b1;
            scan[chord_pos[$urandom_range(0, 2)]] = 1'b1;
            scan[ENTER_IDX] = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) begin
                scan[$urandom_range(0, IN_BITS - 1)] ^= 1'b1;
            end
        end else if (pick < 94) begin
            scan = IN_BITS'({$urandom(), $urandom()});
        end else if (pick < 97) begin
            scan = '0;
        end else begin
            scan = ALL_KEYS;
        end
        return scan;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0) begin
                settle_idle();
            end
            send_scan(next_scan(cur_scan));
        end
        settle_idle();
    endtask

    initial begin
        int  gap;
        logic recv_burst;
        recv_burst = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 47) == 0) begin
                recv_burst = ~recv_burst;
            end
            gap = recv_burst ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_event(m_event_kind, m_key_code);
        end
    end

    initial begin
        logic [IN_BITS-1:0] directed[$];
        sb            = new();
        cur_scan      = '0;
        send_burst    = 1'b0;
        scans_sent    = 0;
        settings_used = 1;
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_SHIFT;
        cfg_wdata  <= '0;
        s_valid    <= 1'b0;
        s_key_down <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset codes: extremes, multi-key edges, chord combinations
        directed = '{
            40'h0, ALL_KEYS, ALL_KEYS, 40'h0, 40'h0,
            40'h1, 40'h3, 40'h2, 40'h0,
            40'h1 << ENTER_IDX, 40'h1 << SHIFT_IDX,
            (40'h1 << SHIFT_IDX) | (40'h1 << ONE_IDX),
            (40'h1 << SHIFT_IDX) | (40'h1 << SPACE_IDX),
            (40'h1 << SPACE_IDX) | (40'h1 << ONE_IDX),
            40'h1 << SPACE_IDX,
            (40'h1 << SPACE_IDX) | (40'h1 << SHIFT_IDX) | (40'h1 << ONE_IDX),
            40'h0, 40'h1 << ONE_IDX, 40'h1 << (ONE_IDX - 1),
            40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h0
        };
        foreach (directed[i]) send_scan(directed[i]);
        settle_idle();
        run_random(150);

        program_codes(8'h00, 8'h00, 8'h00);
        run_random(150);

        program_codes(8'hFF, 8'hFF, 8'hFF);
        run_random(150);

        // shift and enter positions now count toward the chord
        program_codes(CODE_ONE, CODE_SPACE, CODE_W'($urandom_range(0, 255)));
        directed = '{
            (40'h1 << ENTER_IDX) | (40'h1 << SHIFT_IDX), 40'h0,
            40'h1 << ENTER_IDX, (40'h1 << ENTER_IDX) | 40'h1, 40'h0
        };
        foreach (directed[i]) send_scan(directed[i]);
        settle_idle();
        run_random(150);

        // shift code aliases an ordinary key
        program_codes(sb.code_at($urandom_range(0, NKEYS - 1)),
                      CODE_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)));
        run_random(150);

        program_codes(CODE_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)),
                      CODE_W'($urandom_range(0, 255)));
        run_random(150);

        settle_idle();
        repeat (10) @(posedge aclk);
        if (sb.pending_events.size() != 0) begin
            $display("%0t: %0d events never arrived", $time, sb.pending_events.size());
            sb.errors++;
        end
        $display("Sent %0d scans over %0d code settings; %0d events checked",
                 scans_sent, settings_used, sb.checked);
        $display("Predicted %0d presses, %0d releases, %0d escape substitutions",
                 sb.presses, sb.releases, sb.escapes);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
hdl/kmes_pkg.sv
hdl/kmes_lane.sv
hdl/kmes_merge.sv
hdl/key_matrix_edge_scanner.sv
dv/tb.sv
